>>> design/moi_pkg.sv
// Shared types and constants for the mecanum odometry integrator.
// No dependencies; used by moi_ctrl, moi_dp and the top level.
`default_nettype none
package moi_pkg;

    localparam int ATAN_ENTRIES = 24;
    localparam int ANG_W        = 36;   // CORDIC angle, Q.30 radians
    localparam int XY_W         = 34;   // CORDIC vector, Q.30
    localparam int DIV_W        = 68;   // rotated sum before the divide
    localparam int REM_W        = 7;    // remainder of the divide by 125
    localparam int ACC_W        = 48;

    // divide by 128000 = shift by 10, then divide by 125 in 16-bit chunks
    localparam int DIV_PRE    = 10;
    localparam int DIV_CHUNK  = 16;
    localparam int DIV_CHUNKS = 4;
    localparam int RECIP_SH   = 30;

    localparam logic signed [XY_W-1:0]  CORDIC_X0   = 34'sd652032874;
    localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic [23:0]             RECIP_125   = 24'd8589935;  // ceil(2^30/125)
    localparam logic [REM_W-1:0]        DIV_125     = 7'd125;
    localparam logic [DIV_W-1:0]        DIV_ROUND   = 68'd64000;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CORDIC, ST_GAIN, ST_ROTA, ST_ROTB, ST_SUM, ST_DIV, ST_ACC, ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic cordic;
        logic gain;
        logic rota;
        logic rotb;
        logic sum;
        logic div;
        logic acc;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic compute;
        logic cordic_last;
        logic div_last;
    } t_status;

    function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] i);
        logic signed [ANG_W-1:0] v;
        case (i)
            5'd0:  v = 36'sd843314856;
            5'd1:  v = 36'sd497837829;
            5'd2:  v = 36'sd263043836;
            5'd3:  v = 36'sd133525158;
            5'd4:  v = 36'sd67021686;
            5'd5:  v = 36'sd33543515;
            5'd6:  v = 36'sd16775850;
            5'd7:  v = 36'sd8388437;
            5'd8:  v = 36'sd4194282;
            5'd9:  v = 36'sd2097149;
            5'd10: v = 36'sd1048575;
            5'd11: v = 36'sd524287;
            5'd12: v = 36'sd262143;
            5'd13: v = 36'sd131071;
            5'd14: v = 36'sd65535;
            5'd15: v = 36'sd32767;
            5'd16: v = 36'sd16383;
            5'd17: v = 36'sd8191;
            5'd18: v = 36'sd4095;
            5'd19: v = 36'sd2047;
            5'd20: v = 36'sd1023;
            5'd21: v = 36'sd511;
            5'd22: v = 36'sd255;
            5'd23: v = 36'sd127;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> design/moi_ctrl.sv
// Sequencer for the odometry integrator: steps the datapath through one word.
// Depends on moi_pkg.
`default_nettype none
module moi_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    input  moi_pkg::t_status i_status,
    output moi_pkg::t_cmd    o_cmd
);
    moi_pkg::t_state r_state, n_state;
    logic            r_valid, n_valid;
    logic            w_accept, w_pub;

    assign w_accept = i_in_valid && (r_state == moi_pkg::ST_IDLE);
    assign w_pub    = (r_state == moi_pkg::ST_DONE) && (!r_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            moi_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = i_status.compute ? moi_pkg::ST_CORDIC : moi_pkg::ST_DONE;
                end
            end
            moi_pkg::ST_CORDIC: begin
                if (i_status.cordic_last) n_state = moi_pkg::ST_GAIN;
            end
            moi_pkg::ST_GAIN: n_state = moi_pkg::ST_ROTA;
            moi_pkg::ST_ROTA: n_state = moi_pkg::ST_ROTB;
            moi_pkg::ST_ROTB: n_state = moi_pkg::ST_SUM;
            moi_pkg::ST_SUM:  n_state = moi_pkg::ST_DIV;
            moi_pkg::ST_DIV: begin
                if (i_status.div_last) n_state = moi_pkg::ST_ACC;
            end
            moi_pkg::ST_ACC:  n_state = moi_pkg::ST_DONE;
            moi_pkg::ST_DONE: begin
                if (w_pub) n_state = moi_pkg::ST_IDLE;
            end
            default: n_state = moi_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = (r_state == moi_pkg::ST_IDLE);
        o_cmd         = '0;
        o_cmd.load    = w_accept;
        o_cmd.cordic  = (r_state == moi_pkg::ST_CORDIC);
        o_cmd.gain    = (r_state == moi_pkg::ST_GAIN);
        o_cmd.rota    = (r_state == moi_pkg::ST_ROTA);
        o_cmd.rotb    = (r_state == moi_pkg::ST_ROTB);
        o_cmd.sum     = (r_state == moi_pkg::ST_SUM);
        o_cmd.div     = (r_state == moi_pkg::ST_DIV);
        o_cmd.acc     = (r_state == moi_pkg::ST_ACC);
        o_cmd.publish = w_pub;
        o_out_valid   = r_valid;
        n_valid       = w_pub ? 1'b1 : (i_out_ready ? 1'b0 : r_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= moi_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end
endmodule
`default_nettype wire

>>> design/moi_dp.sv
// Datapath: base counts, mecanum sums, CORDIC, gain and rotation products,
// divide by 128000, saturating accumulators and output register. Uses moi_pkg.
`default_nettype none
module moi_dp #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  moi_pkg::t_cmd      i_cmd,
    output moi_pkg::t_status   o_status,
    input  wire                i_func,
    input  wire                i_read_ok,
    input  wire  signed [31:0] i_count_fl,
    input  wire  signed [31:0] i_count_fr,
    input  wire  signed [31:0] i_count_rl,
    input  wire  signed [31:0] i_count_rr,
    input  wire  signed [15:0] i_yaw,
    input  wire         [23:0] i_fwd_gain,
    input  wire         [23:0] i_side_gain,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [15:0] o_heading,
    output logic               o_integrated
);
    localparam int NSTEPS = (CORDIC_STEPS > moi_pkg::ATAN_ENTRIES) ?
                            moi_pkg::ATAN_ENTRIES : CORDIC_STEPS;
    localparam int AW = moi_pkg::ANG_W;
    localparam int XW = moi_pkg::XY_W;
    localparam int DW = moi_pkg::DIV_W;
    localparam int RW = moi_pkg::REM_W;
    localparam int KW = moi_pkg::DIV_CHUNK;
    localparam int WW = moi_pkg::DIV_CHUNK * moi_pkg::DIV_CHUNKS;

    logic        [31:0]    r_base [4];
    logic                  r_first, r_rebase, r_integ;
    logic signed [47:0]    r_acc_x, r_acc_y;
    logic signed [15:0]    r_heading;
    logic signed [33:0]    r_sf, r_ss;
    logic signed [XW-1:0]  r_x, r_y;
    logic signed [AW-1:0]  r_z;
    logic                  r_neg;
    logic        [4:0]     r_step;
    logic signed [48:0]    r_fmm, r_smm;
    logic signed [17:0]    r_cs, r_sn;
    logic signed [66:0]    r_p0, r_p1, r_p2, r_p3;
    logic        [DW-1:0]  r_qx, r_qy;
    logic        [RW-1:0]  r_rx, r_ry;
    logic                  r_sx, r_sy;
    logic        [1:0]     r_cnt;

    logic        [31:0]    w_dfl, w_dfr, w_drl, w_drr;
    logic signed [33:0]    w_sf, w_ss;
    logic signed [AW-1:0]  w_ang;
    logic signed [XW-1:0]  w_xs, w_ys, w_xf, w_yf;
    logic signed [58:0]    w_pf, w_ps;
    logic signed [67:0]    w_vx, w_vy;
    logic        [DW-1:0]  w_mx, w_my;
    logic        [RW+KW-1:0]    w_nx, w_ny;
    logic        [RW+KW+23:0]   w_px, w_py;
    logic        [KW-1:0]  w_dqx, w_dqy;
    logic        [RW-1:0]  w_drx, w_dry;
    logic signed [68:0]    w_sumx, w_sumy;

    assign o_status.compute     = (i_func == moi_pkg::FUNC_SAMPLE) && i_read_ok
                                  && !r_rebase && !r_first;
    assign o_status.cordic_last = (r_step == 5'(NSTEPS - 1));
    assign o_status.div_last    = (r_cnt == 2'(moi_pkg::DIV_CHUNKS - 1));

    function automatic logic signed [47:0] sat_acc(input logic signed [68:0] v);
        logic signed [47:0] r;
        if (v > 69'sh0_7FFF_FFFF_FFFF)       r = 48'sh7FFF_FFFF_FFFF;
        else if (v < -69'sh0_8000_0000_0000) r = 48'sh8000_0000_0000;
        else                                 r = v[47:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sh0000_7FFF_FFFF)       r = 32'sh7FFF_FFFF;
        else if (v < -48'sh0000_8000_0000) r = 32'sh8000_0000;
        else                               r = v[31:0];
        return r;
    endfunction

    always_comb begin
        w_dfl = i_count_fl - r_base[0];
        w_dfr = i_count_fr - r_base[1];
        w_drl = i_count_rl - r_base[2];
        w_drr = i_count_rr - r_base[3];
        w_sf  = 34'($signed(w_dfl)) - 34'($signed(w_dfr))
              + 34'($signed(w_drl)) - 34'($signed(w_drr));
        w_ss  = 34'($signed(w_drl)) + 34'($signed(w_drr))
              - 34'($signed(w_dfl)) - 34'($signed(w_dfr));
        w_ang = AW'(i_yaw) <<< 17;
        w_xs  = r_x >>> r_step;
        w_ys  = r_y >>> r_step;
        w_xf  = r_neg ? -r_x : r_x;
        w_yf  = r_neg ? -r_y : r_y;
        w_pf  = r_sf * $signed({1'b0, i_fwd_gain});
        w_ps  = r_ss * $signed({1'b0, i_side_gain});
        w_vx  = 68'(r_p0) - 68'(r_p1);
        w_vy  = 68'(r_p2) + 68'(r_p3);
        w_mx  = (w_vx[67] ? DW'(-w_vx) : DW'(w_vx)) + moi_pkg::DIV_ROUND;
        w_my  = (w_vy[67] ? DW'(-w_vy) : DW'(w_vy)) + moi_pkg::DIV_ROUND;
        // one 16-bit chunk of the divide by 125: reciprocal multiply, exact for
        // chunk values below 125 * 2^16
        w_nx  = {r_rx, r_qx[WW-1 -: KW]};
        w_ny  = {r_ry, r_qy[WW-1 -: KW]};
        w_px  = w_nx * moi_pkg::RECIP_125;
        w_py  = w_ny * moi_pkg::RECIP_125;
        w_dqx = w_px[moi_pkg::RECIP_SH +: KW];
        w_dqy = w_py[moi_pkg::RECIP_SH +: KW];
        w_drx = w_nx[RW-1:0] - RW'(w_dqx * moi_pkg::DIV_125);
        w_dry = w_ny[RW-1:0] - RW'(w_dqy * moi_pkg::DIV_125);
        w_sumx = 69'(r_acc_x) + (r_sx ? -69'(r_qx[WW-1:0]) : 69'(r_qx[WW-1:0]));
        w_sumy = 69'(r_acc_y) + (r_sy ? -69'(r_qy[WW-1:0]) : 69'(r_qy[WW-1:0]));
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first   <= 1'b1;
            r_rebase  <= 1'b0;
            r_acc_x   <= '0;
            r_acc_y   <= '0;
            r_heading <= '0;
            r_integ   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_integ <= 1'b0;
                if (i_func == moi_pkg::FUNC_CLEAR) begin
                    r_acc_x  <= '0;
                    r_acc_y  <= '0;
                    r_rebase <= 1'b1;
                end else if (i_read_ok) begin
                    if (r_rebase)     r_rebase <= 1'b0;
                    else if (r_first) r_first  <= 1'b0;
                    else begin
                        r_integ   <= 1'b1;
                        r_heading <= i_yaw;
                    end
                end
            end
            if (i_cmd.acc) begin
                r_acc_x <= sat_acc(w_sumx);
                r_acc_y <= sat_acc(w_sumy);
            end
        end
    end

    // payload pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if ((i_func == moi_pkg::FUNC_SAMPLE) && i_read_ok) begin
                r_base[0] <= i_count_fl;
                r_base[1] <= i_count_fr;
                r_base[2] <= i_count_rl;
                r_base[3] <= i_count_rr;
            end
            r_sf   <= w_sf;
            r_ss   <= w_ss;
            r_x    <= moi_pkg::CORDIC_X0;
            r_y    <= '0;
            r_step <= '0;
            if (w_ang > moi_pkg::HALF_PI_Q30) begin
                r_z   <= w_ang - moi_pkg::PI_Q30;
                r_neg <= 1'b1;
            end else if (w_ang < -moi_pkg::HALF_PI_Q30) begin
                r_z   <= w_ang + moi_pkg::PI_Q30;
                r_neg <= 1'b1;
            end else begin
                r_z   <= w_ang;
                r_neg <= 1'b0;
            end
        end
        if (i_cmd.cordic) begin
            if (!r_z[AW-1]) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - moi_pkg::atan_q30(r_step);
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + moi_pkg::atan_q30(r_step);
            end
            r_step <= r_step + 5'd1;
        end
        if (i_cmd.gain) begin
            r_fmm <= 49'((w_pf + 59'sd512) >>> 10);
            r_smm <= 49'((w_ps + 59'sd512) >>> 10);
            r_cs  <= 18'((w_xf + 34'sd32768) >>> 16);
            r_sn  <= 18'((w_yf + 34'sd32768) >>> 16);
        end
        if (i_cmd.rota) begin
            r_p0 <= r_fmm * r_cs;
            r_p1 <= r_smm * r_sn;
        end
        if (i_cmd.rotb) begin
            r_p2 <= r_fmm * r_sn;
            r_p3 <= r_smm * r_cs;
        end
        if (i_cmd.sum) begin
            r_qx  <= w_mx >> moi_pkg::DIV_PRE;
            r_qy  <= w_my >> moi_pkg::DIV_PRE;
            r_sx  <= w_vx[67];
            r_sy  <= w_vy[67];
            r_rx  <= '0;
            r_ry  <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div) begin
            // quotient chunks shift in at the bottom, dividend chunks leave the top
            r_rx  <= w_drx;
            r_ry  <= w_dry;
            r_qx  <= {r_qx[DW-KW-1:0], w_dqx};
            r_qy  <= {r_qy[DW-KW-1:0], w_dqy};
            r_cnt <= r_cnt + 2'd1;
        end
        if (i_cmd.publish) begin
            o_pos_x      <= sat32(r_acc_x);
            o_pos_y      <= sat32(r_acc_y);
            o_heading    <= r_heading;
            o_integrated <= r_integ;
        end
    end
endmodule
`default_nettype wire

>>> design/mecanum_odometry_integrator_top.sv
// Top level of the mecanum odometry integrator: APB gain registers and the
// controller/datapath pair. Depends on moi_pkg, moi_ctrl and moi_dp.
`default_nettype none
// Dead-reckoning integrator for a four-wheel mecanum base. Each input word
// holds four absolute encoder counts and an IMU yaw (Q3.13 rad) in s_tdata,
// and {read_ok, func} in s_tuser. A clear word (func=1) zeroes the position
// and makes the next good sample the new base; a failed read changes nothing;
// the first good sample only sets the base. Every word returns exactly one
// output word: saturated Q16.16 x and y, the last applied heading, and a
// flag in m_tuser that is set when the word moved the estimate.
// Sequence: a word that does not integrate goes straight to the done state
// and is written to the output register from there; the next word can be
// taken after that. An integrating word takes min(CORDIC_STEPS,24) CORDIC
// iterations, a gain step, two rotation product steps, a sum, the four
// 16-bit-chunk steps of the divide by 128000 and an accumulate before its
// result is written. One word is in flight at a time; the next is taken
// while the result waits on m_tready, and a finished word waits until the
// previous result is taken.
// Gains: fwd_gain at byte address 0, side_gain at 4 (24-bit, Q8.16).
module mecanum_odometry_integrator_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // APB configuration port
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [2:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // input stream
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [143:0] s_tdata,   // count_front_left, count_front_right,
                                    // count_rear_left, count_rear_right, yaw_angle
    input  wire  [1:0]   s_tuser,   // func, read_ok
    // output stream
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [79:0]  m_tdata,   // pos_x, pos_y, heading
    output logic         m_tuser    // integrated
);
    logic [23:0]      r_fwd_gain, r_side_gain;
    moi_pkg::t_cmd    w_cmd;
    moi_pkg::t_status w_status;

    // gains are read by the datapath in its gain step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_gain  <= 24'd65536;
            r_side_gain <= 24'd65536;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) r_side_gain <= pwdata[23:0];
            else          r_fwd_gain  <= pwdata[23:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {8'd0, r_side_gain} : {8'd0, r_fwd_gain};

    moi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_tvalid),
        .o_in_ready  (s_tready),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    moi_dp #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_func       (s_tuser[0]),
        .i_read_ok    (s_tuser[1]),
        .i_count_fl   (s_tdata[31:0]),
        .i_count_fr   (s_tdata[63:32]),
        .i_count_rl   (s_tdata[95:64]),
        .i_count_rr   (s_tdata[127:96]),
        .i_yaw        (s_tdata[143:128]),
        .i_fwd_gain   (r_fwd_gain),
        .i_side_gain  (r_side_gain),
        .o_pos_x      (m_tdata[31:0]),
        .o_pos_y      (m_tdata[63:32]),
        .o_heading    (m_tdata[79:64]),
        .o_integrated (m_tuser)
    );
endmodule
`default_nettype wire
